/* rtl/tcw_pkg.sv */
// tcw_pkg: shared constants, codes and types of the text console writer
// used by every module of the block; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int NUM_COLS   = 80;
  localparam int NUM_ROWS   = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = NUM_COLS * NUM_ROWS;
  localparam int MOVE_COUNT = CELL_COUNT - NUM_COLS;

  // internal widths
  localparam int COL_W  = $clog2(NUM_COLS);
  localparam int ROW_W  = $clog2(NUM_ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int TS_W   = $clog2(NUM_COLS + TAB_WIDTH);

  // port field widths
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int CLASS_W    = 2;
  localparam int IN_COL_W   = 7;
  localparam int IN_ROW_W   = 5;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int OFS_W      = 11;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = ATTR_W + CHAR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // colour classes
  localparam logic [CLASS_W-1:0] CLASS_KERNEL = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_USER   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_NORMAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_KERNEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_USER   = 2'd2;

  localparam logic [ATTR_W-1:0] COLOR_NORMAL_RESET = 8'd7;
  localparam logic [ATTR_W-1:0] COLOR_KERNEL_RESET = 8'd4;
  localparam logic [ATTR_W-1:0] COLOR_USER_RESET   = 8'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PRINT  = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_SETCUR = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PUT,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_CLEAR,
    OP_SETCUR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] cell_val;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [ATTR_W-1:0] normal;
    logic [ATTR_W-1:0] kernel;
    logic [ATTR_W-1:0] user;
  } colors_t;

  typedef struct packed {
    logic init_busy;
    logic reporting;
  } status_t;

  // next tab stop for every column, worked out at elaboration
  function automatic logic [NUM_COLS*TS_W-1:0] tab_stops_init();
    logic [NUM_COLS*TS_W-1:0] t;
    t = '0;
    for (int i = 0; i < NUM_COLS; i++) begin
      t[i*TS_W +: TS_W] = TS_W'((i / TAB_WIDTH + 1) * TAB_WIDTH);
    end
    return t;
  endfunction

  localparam logic [NUM_COLS*TS_W-1:0] TAB_STOPS = tab_stops_init();

endpackage

`default_nettype wire

/* rtl/tcw_front.sv */
// tcw_front: colour registers and classification of input items into commands
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tcw_pkg::MODE_W-1:0]     mode,
  input  logic [tcw_pkg::CHAR_W-1:0]     character,
  input  logic [tcw_pkg::CLASS_W-1:0]    attr_class,
  input  logic [tcw_pkg::IN_COL_W-1:0]   col,
  input  logic [tcw_pkg::IN_ROW_W-1:0]   row,
  output tcw_pkg::cmd_t                  cmd
);

  tcw_pkg::colors_t              colors;
  logic [tcw_pkg::ATTR_W-1:0]    attr;
  logic [tcw_pkg::COL_W-1:0]     col_c;
  logic [tcw_pkg::ROW_W-1:0]     row_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors.normal <= tcw_pkg::COLOR_NORMAL_RESET;
      colors.kernel <= tcw_pkg::COLOR_KERNEL_RESET;
      colors.user   <= tcw_pkg::COLOR_USER_RESET;
    end else if (cfg_we) begin
      priority case (cfg_index)
        tcw_pkg::REG_COLOR_NORMAL: colors.normal <= cfg_data[tcw_pkg::ATTR_W-1:0];
        tcw_pkg::REG_COLOR_KERNEL: colors.kernel <= cfg_data[tcw_pkg::ATTR_W-1:0];
        tcw_pkg::REG_COLOR_USER:   colors.user   <= cfg_data[tcw_pkg::ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (attr_class)
      tcw_pkg::CLASS_KERNEL: attr = colors.kernel;
      tcw_pkg::CLASS_USER:   attr = colors.user;
      default:               attr = colors.normal;
    endcase

    col_c = (32'(col) > tcw_pkg::NUM_COLS - 1) ? tcw_pkg::COL_W'(tcw_pkg::NUM_COLS - 1)
                                               : tcw_pkg::COL_W'(col);
    row_c = (32'(row) > tcw_pkg::NUM_ROWS - 1) ? tcw_pkg::ROW_W'(tcw_pkg::NUM_ROWS - 1)
                                               : tcw_pkg::ROW_W'(row);

    cmd.op       = tcw_pkg::OP_NOP;
    cmd.cell_val = {attr, character};
    cmd.col      = col_c;
    cmd.row      = row_c;
    cmd.addr     = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_c) * tcw_pkg::ADDR_W'(tcw_pkg::NUM_COLS)
                                    + tcw_pkg::ADDR_W'(col_c));

    unique case (tcw_pkg::mode_t'(mode))
      tcw_pkg::MODE_PRINT: begin
        priority case (character)
          tcw_pkg::CH_NUL: cmd.op = tcw_pkg::OP_NOP;
          tcw_pkg::CH_TAB: cmd.op = tcw_pkg::OP_TAB;
          tcw_pkg::CH_CR:  cmd.op = tcw_pkg::OP_CR;
          tcw_pkg::CH_LF:  cmd.op = tcw_pkg::OP_LF;
          tcw_pkg::CH_BS: begin
            cmd.op       = tcw_pkg::OP_BS;
            cmd.cell_val = {attr, tcw_pkg::CH_SPACE};
          end
          default:         cmd.op = tcw_pkg::OP_PUT;
        endcase
      end
      tcw_pkg::MODE_CLEAR: begin
        cmd.op       = tcw_pkg::OP_CLEAR;
        cmd.cell_val = {colors.user, tcw_pkg::CH_NUL};
      end
      tcw_pkg::MODE_SETCUR: cmd.op = tcw_pkg::OP_SETCUR;
      tcw_pkg::MODE_READ:   cmd.op = tcw_pkg::OP_READ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/tcw_queue.sv */
// tcw_queue: short command queue between the front and the back
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tcw_pkg::cmd_t pop_cmd
);

  tcw_pkg::cmd_t               entries [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]  count;
  logic                        push;
  logic                        pop;

  assign push_ready = count != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tcw_back.sv */
// tcw_back: cursor, screen store and command sequencer with the result register
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  tcw_pkg::cmd_t                 cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::OUT_COL_W-1:0] cursor_col,
  output logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row,
  output logic [tcw_pkg::OFS_W-1:0]     cursor_offset,
  output logic [tcw_pkg::CHAR_W-1:0]    read_char,
  output logic [tcw_pkg::ATTR_W-1:0]    read_attr,
  output tcw_pkg::status_t              status
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCROLL,
    S_FILL,
    S_REPORT
  } state_t;

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ADDR = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_MOVE = tcw_pkg::ADDR_W'(tcw_pkg::MOVE_COUNT - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ROW0 = tcw_pkg::ADDR_W'(tcw_pkg::MOVE_COUNT);

  state_t                        state;
  logic [tcw_pkg::COL_W-1:0]     cur_col;
  logic [tcw_pkg::ROW_W-1:0]     cur_row;
  logic [tcw_pkg::ADDR_W-1:0]    ptr;
  logic [tcw_pkg::CELL_W-1:0]    fill_cell;
  logic                          rep_read;

  logic [tcw_pkg::CELL_W-1:0]    mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0]    rdata;
  logic                          mem_we;
  logic [tcw_pkg::ADDR_W-1:0]    mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]    mem_wdata;
  logic [tcw_pkg::ADDR_W-1:0]    mem_raddr;

  logic                          pop;
  logic [tcw_pkg::ADDR_W-1:0]    cur_addr;
  logic [tcw_pkg::COL_W:0]       col_inc;
  logic [tcw_pkg::TS_W-1:0]      tab_stop;
  logic                          wrap_put;
  logic                          wrap_tab;
  logic                          at_last_row;
  logic                          do_newline;

  assign pop       = (state == S_IDLE) && cmd_valid && !out_valid;
  assign cmd_ready = pop;

  assign status.init_busy = state == S_INIT;
  assign status.reporting = state == S_REPORT;

  assign cur_addr    = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(cur_row)
                       * tcw_pkg::ADDR_W'(tcw_pkg::NUM_COLS) + tcw_pkg::ADDR_W'(cur_col));
  assign col_inc     = {1'b0, cur_col} + 1'b1;
  assign tab_stop    = tcw_pkg::TAB_STOPS[cur_col*tcw_pkg::TS_W +: tcw_pkg::TS_W];
  assign wrap_put    = col_inc == (tcw_pkg::COL_W + 1)'(tcw_pkg::NUM_COLS);
  assign wrap_tab    = tab_stop >= tcw_pkg::TS_W'(tcw_pkg::NUM_COLS);
  assign at_last_row = cur_row == tcw_pkg::ROW_W'(tcw_pkg::NUM_ROWS - 1);
  assign do_newline  = pop && ((cmd.op == tcw_pkg::OP_PUT && wrap_put)
                              || (cmd.op == tcw_pkg::OP_TAB && wrap_tab)
                              || cmd.op == tcw_pkg::OP_LF);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = fill_cell;
    mem_raddr = cmd.addr;
    unique case (state)
      S_INIT, S_FILL: mem_we = 1'b1;
      S_IDLE: begin
        // first source of a scroll is the start of the second row
        mem_raddr = (cmd.op == tcw_pkg::OP_READ) ? cmd.addr
                                                 : tcw_pkg::ADDR_W'(tcw_pkg::NUM_COLS);
        if (pop && cmd.op == tcw_pkg::OP_PUT) begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = cmd.cell_val;
        end else if (pop && cmd.op == tcw_pkg::OP_BS && cur_col != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr - tcw_pkg::ADDR_W'(1);
          mem_wdata = cmd.cell_val;
        end
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = rdata;
        mem_raddr = (ptr == LAST_MOVE) ? '0
                    : tcw_pkg::ADDR_W'(32'(ptr) + tcw_pkg::NUM_COLS + 1);
      end
      S_REPORT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      fill_cell <= {tcw_pkg::COLOR_USER_RESET, tcw_pkg::CH_NUL};
      cur_col   <= '0;
      cur_row   <= '0;
      rep_read  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (ptr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state     <= S_REPORT;
            rep_read  <= 1'b0;
            fill_cell <= {cmd.cell_val[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::CH_SPACE};
            unique case (cmd.op)
              tcw_pkg::OP_NOP, tcw_pkg::OP_LF: ;
              tcw_pkg::OP_PUT: cur_col <= col_inc[tcw_pkg::COL_W-1:0];
              tcw_pkg::OP_TAB: cur_col <= tab_stop[tcw_pkg::COL_W-1:0];
              tcw_pkg::OP_CR:  cur_col <= '0;
              tcw_pkg::OP_BS: begin
                if (cur_col != '0) begin
                  cur_col <= cur_col - 1'b1;
                end
              end
              tcw_pkg::OP_CLEAR: begin
                cur_col   <= '0;
                cur_row   <= '0;
                ptr       <= '0;
                fill_cell <= cmd.cell_val;
                state     <= S_FILL;
              end
              tcw_pkg::OP_SETCUR: begin
                cur_col <= cmd.col;
                cur_row <= cmd.row;
              end
              tcw_pkg::OP_READ: rep_read <= 1'b1;
              default: ;
            endcase
            if (do_newline) begin
              cur_col <= '0;
              if (!at_last_row) begin
                cur_row <= cur_row + 1'b1;
              end else begin
                ptr   <= '0;
                state <= S_SCROLL;
              end
            end
          end
        end
        S_SCROLL: begin
          if (ptr == LAST_MOVE) begin
            ptr   <= LAST_ROW0;
            state <= S_FILL;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_FILL: begin
          if (ptr == LAST_ADDR) begin
            state <= S_REPORT;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_REPORT: begin
          out_valid     <= 1'b1;
          cursor_col    <= tcw_pkg::OUT_COL_W'(cur_col);
          cursor_row    <= tcw_pkg::OUT_ROW_W'(cur_row);
          cursor_offset <= tcw_pkg::OFS_W'(cur_addr);
          read_char     <= rep_read ? rdata[tcw_pkg::CHAR_W-1:0] : '0;
          read_attr     <= rep_read ? rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/text_console_writer_core.sv */
// text_console_writer_core: top level of the text console writer
// instantiates tcw_front, tcw_queue and tcw_back; depends on tcw_pkg
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   mode, character, attr_class, col, row
//   out      output     out_valid / out_ready cursor_col, cursor_row, cursor_offset,
//                                             read_char, read_attr
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// a beat enters the command queue on in_valid and in_ready; the back steps through
// issue, report and result slot handover for print, set cursor and read
// a scroll copies rows up and refills the last row (one cell copy or fill a cycle
// on the single write port of the store); clear refills every cell the same way
// after reset a clearing pass over all NUM_COLS*NUM_ROWS cells runs with in_ready low
// a held result stalls the back only; the queue takes two more beats meanwhile
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tcw_pkg::MODE_W-1:0]     mode,
  input  logic [tcw_pkg::CHAR_W-1:0]     character,
  input  logic [tcw_pkg::CLASS_W-1:0]    attr_class,
  input  logic [tcw_pkg::IN_COL_W-1:0]   col,
  input  logic [tcw_pkg::IN_ROW_W-1:0]   row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcw_pkg::OUT_COL_W-1:0]  cursor_col,
  output logic [tcw_pkg::OUT_ROW_W-1:0]  cursor_row,
  output logic [tcw_pkg::OFS_W-1:0]      cursor_offset,
  output logic [tcw_pkg::CHAR_W-1:0]     read_char,
  output logic [tcw_pkg::ATTR_W-1:0]     read_attr
);

  tcw_pkg::cmd_t    front_cmd;
  tcw_pkg::cmd_t    q_cmd;
  tcw_pkg::status_t status;
  logic             q_push_ready;
  logic             q_valid;
  logic             q_ready;
  logic             push_valid;

  assign push_valid = in_valid && !status.init_busy;
  assign in_ready   = q_push_ready && !status.init_busy;

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .character  (character),
    .attr_class (attr_class),
    .col        (col),
    .row        (row),
    .cmd        (front_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  tcw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_offset (cursor_offset),
    .read_char     (read_char),
    .read_attr     (read_attr),
    .status        (status)
  );

  a_queue_empty_in_init: assert property (@(posedge clk) disable iff (rst)
    status.init_busy |-> !q_valid)
    else $error("command queued during the clearing pass");

  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(status.reporting))
    else $error("result raised outside the report step");

  a_report_into_empty_slot: assert property (@(posedge clk) disable iff (rst)
    status.reporting |-> !out_valid)
    else $error("report would overwrite a waiting result");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_col) < tcw_pkg::NUM_COLS)
               && (32'(cursor_row) < tcw_pkg::NUM_ROWS))
    else $error("reported cursor off the screen");

endmodule

`default_nettype wire
